FILE: src/sib_pkg.sv
// ----------------------------------------------------------------------------
// sib_pkg
// Shared types and codes for the sorted insertion buffer.
// ----------------------------------------------------------------------------
package sib_pkg;

    // Default sizing of the store.
    localparam int CAPACITY_DEF   = 16;
    localparam int VALUE_BITS_DEF = 32;

    // Action carried in the input tuser field.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_DUMP   = 1'b1;

    // Status carried in the output tuser field.
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_ENTRY    = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // Operation broadcast from the controller to every cell.
    typedef struct packed {
        logic insert_en;
        logic rotate_en;
    } sib_ctrl_t;

endpackage

FILE: src/sib_cell.sv
// ----------------------------------------------------------------------------
// sib_cell
// One slot of the sorted chain: compares, shifts up on insert, rotates down
// on readout.
// ----------------------------------------------------------------------------
module sib_cell #(
    parameter int VALUE_BITS = sib_pkg::VALUE_BITS_DEF
) (
    input  logic                  aclk,
    input  sib_pkg::sib_ctrl_t    ctrl,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic                  occupied,
    input  logic                  prev_take,
    input  logic [VALUE_BITS-1:0] prev_value,
    input  logic [VALUE_BITS-1:0] next_value,
    input  logic                  wrap_here,
    input  logic [VALUE_BITS-1:0] wrap_value,
    output logic [VALUE_BITS-1:0] stored_value,
    output logic                  take
);

    logic [VALUE_BITS-1:0] stored_reg;
    logic [VALUE_BITS-1:0] stored_next;

    // This slot lies at or past the insert point when it is empty or its
    // value is not smaller than the new one.
    assign take = !(occupied && ($signed(stored_reg) < $signed(ins_value)));

    // On insert, the first taking slot gets the new value and the ones after
    // it take their lower neighbor. On rotate, every slot takes its upper
    // neighbor and the top occupied slot takes the head.
    always_comb begin
        stored_next = stored_reg;
        if (ctrl.insert_en && take) begin
            stored_next = prev_take ? prev_value : ins_value;
        end else if (ctrl.rotate_en) begin
            stored_next = wrap_here ? wrap_value : next_value;
        end
    end

    always_ff @(posedge aclk) begin
        stored_reg <= stored_next;
    end

    assign stored_value = stored_reg;

endmodule

FILE: src/sorted_insertion_buffer_core.sv
// ----------------------------------------------------------------------------
// sorted_insertion_buffer_core
// Bounded store of signed values kept in ascending order in a chain of cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)            tuser                tlast
//  s_       in   value                         action (0 ins,1 dump) -
//  m_       out  data                          status               last
//
//  On an insert every cell compares in parallel and the chain shifts up by
//  one behind the insert point. A dump streams one entry per cycle while m_
//  is not stalled, by rotating the chain down through cell 0, and leaves the
//  order unchanged. No new beat is taken while a dump streams. A stall on
//  m_ holds the output register and pauses the rotation. Reset clears the
//  entry count; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_insertion_buffer_core #(
    parameter int CAPACITY   = sib_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = sib_pkg::VALUE_BITS_DEF,
    localparam int DATA_W    = ((VALUE_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // [VALUE_BITS-1:0] value
    input  logic              s_tuser,   // [0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // [VALUE_BITS-1:0] data
    output logic [1:0]        m_tuser,   // [1:0] status
    output logic              m_tlast
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                  state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VALUE_BITS-1:0] m_data_reg, m_data_next;
    logic [1:0]            m_status_reg, m_status_next;
    logic                  m_last_reg, m_last_next;

    logic                  out_free;
    logic                  accept;
    logic                  full;
    logic [VALUE_BITS-1:0] ins_value;
    sib_pkg::sib_ctrl_t    ctrl;

    logic [VALUE_BITS-1:0] cell_val  [CAPACITY];
    logic                  cell_take [CAPACITY];

    // Handshake and broadcast control.
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign ins_value = s_tdata[VALUE_BITS-1:0];

    assign ctrl.insert_en = accept && (s_tuser == sib_pkg::ACT_INSERT) && !full;
    assign ctrl.rotate_en = (state_reg == S_DUMP) && out_free;

    // Chain of cells.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  prev_take;
        logic [VALUE_BITS-1:0] prev_value;
        logic [VALUE_BITS-1:0] next_value;

        if (i == 0) begin : g_head
            assign prev_take  = 1'b0;
            assign prev_value = '0;
        end else begin : g_body
            assign prev_take  = cell_take[i-1];
            assign prev_value = cell_val[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign next_value = '0;
        end else begin : g_link
            assign next_value = cell_val[i+1];
        end

        sib_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .ins_value    (ins_value),
            .occupied     (CNT_W'(i) < count_reg),
            .prev_take    (prev_take),
            .prev_value   (prev_value),
            .next_value   (next_value),
            .wrap_here    (CNT_W'(i) == (count_reg - CNT_W'(1))),
            .wrap_value   (cell_val[0]),
            .stored_value (cell_val[i]),
            .take         (cell_take[i])
        );
    end

    // Controller and output register.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        if (out_free) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_tuser == sib_pkg::ACT_INSERT) begin
                        m_tvalid_next = 1'b1;
                        m_data_next   = '0;
                        m_last_next   = 1'b1;
                        if (full) begin
                            m_status_next = sib_pkg::ST_DROPPED;
                        end else begin
                            m_status_next = sib_pkg::ST_INSERTED;
                            count_next    = count_reg + CNT_W'(1);
                        end
                    end else if (count_reg == '0) begin
                        m_tvalid_next = 1'b1;
                        m_data_next   = '0;
                        m_status_next = sib_pkg::ST_EMPTY;
                        m_last_next   = 1'b1;
                    end else begin
                        state_next = S_DUMP;
                        idx_next   = '0;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = cell_val[0];
                    m_status_next = sib_pkg::ST_ENTRY;
                    m_last_next   = (idx_reg == (count_reg - CNT_W'(1)));
                    idx_next      = idx_reg + CNT_W'(1);
                    if (idx_reg == (count_reg - CNT_W'(1))) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: src/sib_checker.sv
// ----------------------------------------------------------------------------
// sib_checker
// Port-level checks for the sorted insertion buffer.
// ----------------------------------------------------------------------------
module sib_checker #(
    parameter int DATA_W = sib_pkg::VALUE_BITS_DEF
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [DATA_W-1:0] s_tdata,
    input logic              s_tuser,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [1:0]        m_tuser,
    input logic              m_tlast
);

    // No result beat is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat offered after reset");

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    // Acknowledges and the empty answer are single beats with zero data.
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != sib_pkg::ST_ENTRY) |-> m_tlast && (m_tdata == '0))
        else $error("non-entry result is not a zero last beat");

    // No new beat is taken while a dump is still streaming.
    a_dump_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == sib_pkg::ST_ENTRY) && !m_tlast |-> !s_tready)
        else $error("input taken in the middle of a dump");

    // An accepted insert is answered on the next edge's output register.
    a_insert_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == sib_pkg::ACT_INSERT) |=>
            m_tvalid && ((m_tuser == sib_pkg::ST_INSERTED) ||
                         (m_tuser == sib_pkg::ST_DROPPED)))
        else $error("insert beat not acknowledged");

endmodule

bind sorted_insertion_buffer_core sib_checker #(
    .DATA_W (DATA_W)
) u_sib_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: verif/sib_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sib_scoreboard_pkg
// Scoreboard for the sorted insertion buffer. It keeps its own ascending
// store, predicts the result beats of every accepted input beat, and checks
// each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
package sib_scoreboard_pkg;

    localparam int SB_CAPACITY   = sib_pkg::CAPACITY_DEF;
    localparam int SB_VALUE_BITS = sib_pkg::VALUE_BITS_DEF;
    localparam int SB_DATA_W     = ((SB_VALUE_BITS + 7) / 8) * 8;

    // One predicted result beat.
    typedef struct packed {
        logic [SB_DATA_W-1:0] data;
        logic [1:0]           status;
        logic                 last;
    } sib_result_t;

    class sorted_store_scoreboard;

        logic signed [SB_VALUE_BITS-1:0] stored_values [SB_CAPACITY];
        int                              stored_count;
        sib_result_t                     pending_results [$];

        int unsigned error_count;
        int unsigned checked_count;
        int unsigned insert_count;
        int unsigned dropped_count;
        int unsigned readout_count;
        int unsigned empty_readout_count;

        function new();
            stored_count        = 0;
            error_count         = 0;
            checked_count       = 0;
            insert_count        = 0;
            dropped_count       = 0;
            readout_count       = 0;
            empty_readout_count = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void post_result(input logic [SB_VALUE_BITS-1:0] value,
                                  input logic [1:0] status, input logic last);
            sib_result_t r;
            r.data   = '0;
            r.data[SB_VALUE_BITS-1:0] = value;
            r.status = status;
            r.last   = last;
            pending_results.push_back(r);
        endfunction

        // Update the store for one accepted input beat and queue its results.
        function void note_beat(input logic action, input logic [SB_DATA_W-1:0] word);
            logic signed [SB_VALUE_BITS-1:0] value;
            int                              pos;
            value = word[SB_VALUE_BITS-1:0];
            if (action == sib_pkg::ACT_INSERT) begin
                if (stored_count >= SB_CAPACITY) begin
                    dropped_count++;
                    post_result('0, sib_pkg::ST_DROPPED, 1'b1);
                end else begin
                    // Place the value in front of the first entry that is not smaller.
                    pos = 0;
                    while (pos < stored_count && stored_values[pos] < value)
                        pos++;
                    for (int i = stored_count; i > pos; i--)
                        stored_values[i] = stored_values[i-1];
                    stored_values[pos] = value;
                    stored_count++;
                    insert_count++;
                    post_result('0, sib_pkg::ST_INSERTED, 1'b1);
                end
            end else begin
                readout_count++;
                if (stored_count == 0) begin
                    empty_readout_count++;
                    post_result('0, sib_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < stored_count; i++)
                        post_result(stored_values[i], sib_pkg::ST_ENTRY,
                                    i == stored_count - 1);
                end
            end
        endfunction

        // Compare one accepted result beat with the oldest prediction.
        function void check_result(input logic [SB_DATA_W-1:0] data,
                                   input logic [1:0] status, input logic last);
            sib_result_t want;
            checked_count++;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing predicted: data %h status %0d last %0b",
                       data, status, last);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            if (data !== want.data) begin
                $error("data mismatch: expected %h, actual %h", want.data, data);
                error_count++;
            end
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                error_count++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                error_count++;
            end
        endfunction

    endclass

endpackage

FILE: verif/tb_sorted_insertion_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insertion_buffer_core
// Self-checking bench for the sorted insertion buffer. A directed sequence
// covers the empty readout, extreme and equal values; random inserts then
// fill the store, after which readouts and dropped inserts dominate. Both
// sides idle and stall in several traffic phases.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_buffer_core;

    localparam int RANDOM_ITEMS = 250;
    localparam int PHASE_ITEMS  = 25;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 2 * sib_scoreboard_pkg::SB_CAPACITY + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DATA_W       = sib_scoreboard_pkg::SB_DATA_W;

    // Traffic phases.
    localparam int MODE_FREE      = 0;
    localparam int MODE_SRC_IDLE  = 1;
    localparam int MODE_SINK_IDLE = 2;
    localparam int MODE_BOTH_IDLE = 3;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic              s_tuser  = sib_pkg::ACT_INSERT;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    int   traffic_mode  = MODE_FREE;
    logic hold_request  = 1'b0;
    logic hold_taken    = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;

    sib_scoreboard_pkg::sorted_store_scoreboard sb;

    sorted_insertion_buffer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tuser  (s_tuser),   // [0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] data
        .m_tuser  (m_tuser),   // [1:0] status
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: one long hold-off when requested, otherwise stall per phase.
    always @(posedge aclk) begin
        if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (traffic_mode)
                MODE_SINK_IDLE: m_tready <= ($urandom_range(0, 99) >= 82);
                MODE_BOTH_IDLE: m_tready <= ($urandom_range(0, 99) >= 10);
                default:        m_tready <= 1'b1;
            endcase
        end
    end

    // Result monitor.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    // Offer one beat after a phase-dependent gap and wait for its handshake.
    task automatic send_beat(input logic action, input logic [DATA_W-1:0] word);
        int gap;
        int idle_pct;
        gap = 0;
        case (traffic_mode)
            MODE_SRC_IDLE:  idle_pct = 82;
            MODE_BOTH_IDLE: idle_pct = 10;
            default:        idle_pct = 0;
        endcase
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_beat(action, word);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 8) - 4;   // close values, many equal
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hffff_ffff;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Main stimulus.
    initial begin
        logic action;
        sb = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: empty readout, extremes, equal values, readout.
        send_beat(sib_pkg::ACT_DUMP,   32'h0000_0000);
        send_beat(sib_pkg::ACT_INSERT, 32'h8000_0000);
        send_beat(sib_pkg::ACT_INSERT, 32'h7fff_ffff);
        send_beat(sib_pkg::ACT_INSERT, 32'h0000_0000);
        send_beat(sib_pkg::ACT_INSERT, 32'hffff_ffff);
        send_beat(sib_pkg::ACT_INSERT, 32'h0000_0001);
        send_beat(sib_pkg::ACT_INSERT, 32'h0000_0000);
        send_beat(sib_pkg::ACT_INSERT, 32'h7fff_ffff);
        send_beat(sib_pkg::ACT_INSERT, 32'h8000_0000);
        send_beat(sib_pkg::ACT_DUMP,   32'hffff_ffff);

        // Random part: the store fills, then readouts and dropped inserts.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % PHASE_ITEMS == 0)
                traffic_mode <= (i / PHASE_ITEMS) % 4;
            // Long receiver hold-off while beats keep coming.
            if (i == 100)
                hold_request <= 1'b1;
            // Let everything drain before going on.
            if (i == 150) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            action = ($urandom_range(0, 1) == 0) ? sib_pkg::ACT_INSERT : sib_pkg::ACT_DUMP;
            send_beat(action, pick_value());
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("Run covered %0d inserts, %0d dropped inserts on a full store,",
                 sb.insert_count, sb.dropped_count);
        $display("%0d readouts (%0d of an empty store) and %0d checked result beats.",
                 sb.readout_count, sb.empty_readout_count, sb.checked_count);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
